### rtl/mlfqs_pkg.sv
// ----------------------------------------------------------------------------
// mlfqs_pkg
// Shared types, codes and helpers for the scheduler fixed-point math core.
// ----------------------------------------------------------------------------
package mlfqs_pkg;

   // Item kinds
   typedef enum logic [1:0] {
      KIND_LOAD   = 2'd0,
      KIND_DECAY  = 2'd1,
      KIND_PRIO   = 2'd2,
      KIND_REPORT = 2'd3
   } kind_type;

   // Register indexes
   localparam logic [0:0] CSR_MAX_PRIO = 1'b0;
   localparam logic [0:0] CSR_MIN_PRIO = 1'b1;

   localparam logic [7:0] MAX_PRIO_RESET = 8'd63;
   localparam logic [7:0] MIN_PRIO_RESET = 8'd0;

   // Divide by 15 as multiply and shift, exact for any 32-bit unsigned operand
   localparam logic [31:0] DIV15_MAGIC = 32'h8888_8889;
   localparam int          DIV15_SHIFT = 35;

   // Controller states
   typedef enum logic [2:0] {
      S_IDLE,
      S_PREP,
      S_DIV,
      S_MUL,
      S_FIN
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic div_start;
      logic mul_en;
      logic finish;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic need_div;
      logic div_busy;
   } status_type;

   // Arithmetic shift right that rounds toward zero
   function automatic logic signed [63:0] shr_trunc(input logic signed [63:0] x,
                                                   input int sh);
      logic signed [63:0] bias;
      bias = x[63] ? ((64'sd1 <<< sh) - 64'sd1) : 64'sd0;
      return (x + bias) >>> sh;
   endfunction

endpackage

### rtl/mlfqs_div.sv
// ----------------------------------------------------------------------------
// mlfqs_div
// Signed restoring divider, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module mlfqs_div #(
   parameter int DD_W = 49,
   parameter int DS_W = 35
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic signed [DD_W-1:0] dividend,
   input  logic signed [DS_W-1:0] divisor,
   output logic                   busy,
   output logic signed [DD_W:0]   quotient
);

   localparam int CNT_W = $clog2(DD_W + 1);

   logic [DD_W-1:0]  quo_ff, quo_in;
   logic [DS_W-1:0]  rem_ff, rem_in;
   logic [DS_W-1:0]  dvs_ff, dvs_in;
   logic             neg_ff, neg_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;

   logic [DS_W:0]    rem_sh;
   logic [DS_W:0]    diff;

   // One restoring step per cycle
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      rem_sh  = {rem_ff, quo_ff[DD_W-1]};
      diff    = rem_sh - {1'b0, dvs_ff};
      if (start) begin
         quo_in  = dividend[DD_W-1] ? DD_W'(-dividend) : DD_W'(dividend);
         dvs_in  = divisor[DS_W-1] ? DS_W'(-divisor) : DS_W'(divisor);
         neg_in  = dividend[DD_W-1] ^ divisor[DS_W-1];
         rem_in  = '0;
         cnt_in  = CNT_W'(DD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DS_W]) begin
            rem_in = diff[DS_W-1:0];
            quo_in = {quo_ff[DD_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DS_W-1:0];
            quo_in = {quo_ff[DD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign busy     = busy_ff;
   assign quotient = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});

endmodule

### rtl/mlfqs_dp.sv
// ----------------------------------------------------------------------------
// mlfqs_dp
// Datapath: item registers, load average, clamp registers, divider, multiplier
// and result registers.
// ----------------------------------------------------------------------------
module mlfqs_dp #(
   parameter int FRACTION_BITS = 14,
   parameter int MAX_THREADS   = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mlfqs_pkg::cmd_type    cmd,
   output mlfqs_pkg::status_type status,
   input  logic [1:0]            req_kind,
   input  logic [6:0]            req_ready_count,
   input  logic                  req_running_not_idle,
   input  logic signed [5:0]     req_nice_value,
   input  logic signed [31:0]    req_recent_usage,
   input  logic                  req_thread_is_idle,
   input  logic                  csr_write_en,
   input  logic [0:0]            csr_index,
   input  logic [7:0]            csr_write_data,
   output logic signed [31:0]    rsp_value,
   output logic signed [31:0]    rsp_load_out
);

   localparam int F    = FRACTION_BITS;
   localparam int DD_W = FRACTION_BITS + 35;
   localparam int DS_W = 35;

   mlfqs_pkg::kind_type kind_ff;
   logic [6:0]          count_ff;
   logic                run_ff;
   logic signed [5:0]   nice_ff;
   logic signed [31:0]  recent_ff;
   logic                idle_ff;
   logic signed [31:0]  load_ff, load_in;
   logic [7:0]          max_ff, min_ff;
   logic [31:0]         quarter_ff;
   logic signed [63:0]  prod_ff, lprod_ff;
   logic signed [31:0]  value_ff, value_in;
   logic signed [31:0]  lout_ff, lout_in;

   logic [10:0]         n_sat;
   logic signed [63:0]  ld_sum, twol, den, dvd_wide;
   logic signed [DD_W-1:0] dividend;
   logic signed [DS_W-1:0] divisor;
   logic                den_zero;
   logic                need_div, div_busy;
   logic signed [DD_W:0] quotient;
   logic signed [31:0]  coef;
   logic signed [32:0]  mul_a, mul_b;
   logic signed [63:0]  prio, hi64, lo64;
   logic signed [63:0]  decayed;

   // Item capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff   <= mlfqs_pkg::kind_type'(req_kind);
         count_ff  <= req_ready_count;
         run_ff    <= req_running_not_idle;
         nice_ff   <= req_nice_value;
         recent_ff <= req_recent_usage;
         idle_ff   <= req_thread_is_idle;
      end
   end

   // Load update sum and divider operands
   always_comb begin
      n_sat = ({4'b0, count_ff} > 11'(MAX_THREADS)) ? 11'(MAX_THREADS) : {4'b0, count_ff};
      n_sat = n_sat + {10'b0, run_ff};
      ld_sum   = 64'(load_ff) * 64'sd59 + (64'($signed({1'b0, n_sat})) <<< F);
      twol     = 64'(load_ff) <<< 1;
      den      = twol + (64'sd1 <<< F);
      den_zero = (den == 64'sd0);
      dvd_wide = twol <<< F;
      dividend = DD_W'(dvd_wide);
      divisor  = DS_W'(den);
      need_div = (kind_ff == mlfqs_pkg::KIND_DECAY) && !idle_ff && !den_zero;
   end

   assign status = '{need_div: need_div, div_busy: div_busy};

   // Load sum over four; the load never goes negative so this floors
   always_ff @(posedge clock) begin
      quarter_ff <= 32'(ld_sum >>> 2);
   end

   mlfqs_div #(
      .DD_W (DD_W),
      .DS_W (DS_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .busy     (div_busy),
      .quotient (quotient)
   );

   // Multiplier stage: divide by 60 is the quarter times the 1/15 reciprocal
   assign coef = den_zero ? 32'sd0 : 32'(quotient);

   always_comb begin
      if (kind_ff == mlfqs_pkg::KIND_LOAD) begin
         mul_a = $signed({1'b0, quarter_ff});
         mul_b = $signed({1'b0, mlfqs_pkg::DIV15_MAGIC});
      end else if (kind_ff == mlfqs_pkg::KIND_DECAY) begin
         mul_a = 33'(coef);
         mul_b = 33'(recent_ff);
      end else begin
         mul_a = 33'sd100;
         mul_b = 33'(recent_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff  <= 64'(mul_a) * 64'(mul_b);
         lprod_ff <= 64'(load_ff) * 64'sd100;
      end
   end

   // Result formation
   always_comb begin
      load_in  = load_ff;
      value_in = 32'sd0;
      lout_in  = load_ff;
      hi64     = 64'($signed({1'b0, max_ff}));
      lo64     = 64'($signed({1'b0, min_ff}));
      decayed  = 64'(32'(mlfqs_pkg::shr_trunc(prod_ff, F)));
      prio     = mlfqs_pkg::shr_trunc((hi64 <<< F)
                    - mlfqs_pkg::shr_trunc(64'(recent_ff), 2)
                    - (64'(nice_ff) <<< (F + 1)), F);
      if (prio > hi64) begin
         prio = hi64;
      end else if (prio < lo64) begin
         prio = lo64;
      end
      unique case (kind_ff)
         mlfqs_pkg::KIND_LOAD: begin
            load_in = 32'(prod_ff >>> mlfqs_pkg::DIV15_SHIFT);
            lout_in = 32'(prod_ff >>> mlfqs_pkg::DIV15_SHIFT);
         end
         mlfqs_pkg::KIND_DECAY: begin
            value_in = idle_ff ? recent_ff
                               : 32'((64'(nice_ff) <<< F) + decayed);
         end
         mlfqs_pkg::KIND_PRIO: begin
            value_in = 32'(prio);
         end
         mlfqs_pkg::KIND_REPORT: begin
            value_in = 32'(mlfqs_pkg::shr_trunc(prod_ff, F));
            lout_in  = 32'(mlfqs_pkg::shr_trunc(lprod_ff, F));
         end
         default: begin
            value_in = 32'sd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         value_ff <= value_in;
         lout_ff  <= lout_in;
      end
   end

   // Load average and clamp registers
   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff <= 32'sd0;
         max_ff  <= mlfqs_pkg::MAX_PRIO_RESET;
         min_ff  <= mlfqs_pkg::MIN_PRIO_RESET;
      end else begin
         if (cmd.finish) begin
            load_ff <= load_in;
         end
         if (csr_write_en) begin
            unique case (csr_index)
               mlfqs_pkg::CSR_MAX_PRIO: max_ff <= csr_write_data;
               mlfqs_pkg::CSR_MIN_PRIO: min_ff <= csr_write_data;
               default: ;
            endcase
         end
      end
   end

   assign rsp_value    = value_ff;
   assign rsp_load_out = lout_ff;

endmodule

### rtl/mlfqs_ctrl.sv
// ----------------------------------------------------------------------------
// mlfqs_ctrl
// Controller: sequences capture, divide, multiply and finish; owns rsp_valid.
// ----------------------------------------------------------------------------
module mlfqs_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output mlfqs_pkg::cmd_type    cmd,
   input  mlfqs_pkg::status_type status
);

   mlfqs_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic slot_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mlfqs_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      slot_free     = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      req_stall     = (state_ff != mlfqs_pkg::S_IDLE);
      unique case (state_ff)
         mlfqs_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = mlfqs_pkg::S_PREP;
            end
         end
         mlfqs_pkg::S_PREP: begin
            if (status.need_div) begin
               cmd.div_start = 1'b1;
               state_in      = mlfqs_pkg::S_DIV;
            end else begin
               state_in = mlfqs_pkg::S_MUL;
            end
         end
         mlfqs_pkg::S_DIV: begin
            if (!status.div_busy) begin
               state_in = mlfqs_pkg::S_MUL;
            end
         end
         mlfqs_pkg::S_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = mlfqs_pkg::S_FIN;
         end
         mlfqs_pkg::S_FIN: begin
            if (slot_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = mlfqs_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = mlfqs_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTH
   // A result never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !(rsp_valid_ff && rsp_stall))
      else $error("result overwritten while stalled");

   // Divider runs after each start
   a_div_runs: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> status.div_busy)
      else $error("divider did not start");

   // A new result only follows a finish
   a_valid_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.finish))
      else $error("result valid without finish");
`endif

endmodule

### rtl/mlfqs_fixed_point_scheduler_math_core.sv
// ----------------------------------------------------------------------------
// mlfqs_fixed_point_scheduler_math_core
// Load average, recent-cpu decay, priority and scaled report in signed
// fixed point with FRACTION_BITS fraction bits.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | kind, count, busy, nice, recent, idle
//  rsp     | out       | rsp_valid/rsp_stall  | value, load_out
//  csr     | in        | csr_write_en         | csr_index, csr_write_data
//
//  Decays that divide run the bit-serial divider in S_DIV; other items, load
//  updates included, go from S_PREP straight on to S_MUL and S_FIN.
//  One item is in work at a time; the output register holds a result while
//  rsp_stall is high and the next item is still accepted.
//  Reset (synchronous) clears the load average and loads the clamp defaults.
// ----------------------------------------------------------------------------
module mlfqs_fixed_point_scheduler_math_core #(
   parameter int FRACTION_BITS = 14,
   parameter int MAX_THREADS   = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_kind,
   input  logic [6:0]         req_ready_count,
   input  logic               req_running_not_idle,
   input  logic signed [5:0]  req_nice_value,
   input  logic signed [31:0] req_recent_usage,
   input  logic               req_thread_is_idle,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_value,
   output logic signed [31:0] rsp_load_out,
   input  logic               csr_write_en,
   input  logic [0:0]         csr_index,
   input  logic [7:0]         csr_write_data
);

   mlfqs_pkg::cmd_type    cmd;
   mlfqs_pkg::status_type status;

   mlfqs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   mlfqs_dp #(
      .FRACTION_BITS (FRACTION_BITS),
      .MAX_THREADS   (MAX_THREADS)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_kind             (req_kind),
      .req_ready_count      (req_ready_count),
      .req_running_not_idle (req_running_not_idle),
      .req_nice_value       (req_nice_value),
      .req_recent_usage     (req_recent_usage),
      .req_thread_is_idle   (req_thread_is_idle),
      .csr_write_en         (csr_write_en),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .rsp_value            (rsp_value),
      .rsp_load_out         (rsp_load_out)
   );

endmodule

### dv/mlfqs_math_checker.sv
// ----------------------------------------------------------------------------
// mlfqs_math_checker
// Watches the request and response channels of the scheduler math core,
// predicts each response from its own copy of the load average and clamp
// registers, and compares every field in order. Counts mismatches.
// ----------------------------------------------------------------------------
module mlfqs_math_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [1:0]         req_kind,
   input  logic [6:0]         req_ready_count,
   input  logic               req_running_not_idle,
   input  logic signed [5:0]  req_nice_value,
   input  logic signed [31:0] req_recent_usage,
   input  logic               req_thread_is_idle,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [31:0] rsp_value,
   input  logic signed [31:0] rsp_load_out,
   input  logic               csr_write_en,
   input  logic [0:0]         csr_index,
   input  logic [7:0]         csr_write_data,
   output int                 fail_count,
   output int                 pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC = 14;
   localparam int THREAD_CAP = 64;
   localparam longint ONE = 64'sd1 << FRAC;

   typedef struct packed {
      logic signed [31:0] value;
      logic signed [31:0] load;
   } sched_result_type;

   sched_result_type expected_q[$];
   logic signed [31:0] load_avg;
   logic [7:0] prio_hi, prio_lo;

   assign pending_count = expected_q.size();

   // Work out the response for one request and advance the load average
   function automatic sched_result_type compute_sched(input logic [1:0] kind_raw,
         input logic [6:0] cnt, input logic busy, input logic signed [5:0] nice6,
         input logic signed [31:0] rec32, input logic idle);
      sched_result_type r;
      mlfqs_pkg::kind_type k;
      longint n, twol, den, coef, dec, p, nice, rec, la, hi, lo;
      k = mlfqs_pkg::kind_type'(kind_raw);
      nice = nice6;
      rec = rec32;
      la = load_avg;
      hi = prio_hi;
      lo = prio_lo;
      r.value = '0;
      r.load = load_avg;
      case (k)
         mlfqs_pkg::KIND_LOAD: begin
            n = (cnt > THREAD_CAP) ? THREAD_CAP : cnt;
            n = n + busy;
            load_avg = 32'((59 * la + n * ONE) / 60);
            r.load = load_avg;
         end
         mlfqs_pkg::KIND_DECAY: begin
            if (idle) begin
               r.value = rec32;
            end else begin
               twol = 2 * la;
               den = ONE + twol;
               coef = 0;
               if (den != 0) coef = longint'(signed'(32'(twol * ONE / den)));
               dec = longint'(signed'(32'(coef * rec / ONE)));
               r.value = 32'(nice * ONE + dec);
            end
         end
         mlfqs_pkg::KIND_PRIO: begin
            p = (hi * ONE - rec / 4 - 2 * nice * ONE) / ONE;
            if (p > hi) p = hi;
            else if (p < lo) p = lo;
            r.value = 32'(p);
         end
         default: begin
            r.value = 32'(rec * 100 / ONE);
            r.load = 32'(la * 100 / ONE);
         end
      endcase
      return r;
   endfunction

   // Track registers, predict on accept, compare on response
   always @(posedge clock) begin
      sched_result_type want;
      int errs;
      errs = 0;
      if (reset) begin
         load_avg <= '0;
         prio_hi <= mlfqs_pkg::MAX_PRIO_RESET;
         prio_lo <= mlfqs_pkg::MIN_PRIO_RESET;
         expected_q.delete();
         fail_count <= 0;
      end else begin
         if (csr_write_en) begin
            if (csr_index == mlfqs_pkg::CSR_MAX_PRIO) prio_hi = csr_write_data;
            else prio_lo = csr_write_data;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               $error("response with nothing expected: value %0d load %0d",
                      rsp_value, rsp_load_out);
               errs++;
            end else begin
               want = expected_q.pop_front();
               if (want.value !== rsp_value) begin
                  $error("value: expected %0d, got %0d", want.value, rsp_value);
                  errs++;
               end
               if (want.load !== rsp_load_out) begin
                  $error("load_out: expected %0d, got %0d", want.load, rsp_load_out);
                  errs++;
               end
            end
         end
         if (errs != 0)
            fail_count <= fail_count + errs;
         if (req_valid && !req_stall)
            expected_q.push_back(compute_sched(req_kind, req_ready_count,
               req_running_not_idle, req_nice_value, req_recent_usage,
               req_thread_is_idle));
      end
   end
endmodule

### dv/mlfqs_fixed_point_scheduler_math_core_tb.sv
// ----------------------------------------------------------------------------
// mlfqs_fixed_point_scheduler_math_core_tb
// Drives directed and random items into the math core under several clamp
// settings with random gaps and response stalls; the checker does the rest.
// ----------------------------------------------------------------------------
module mlfqs_fixed_point_scheduler_math_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic               clock, reset;
   logic               req_valid, req_stall;
   logic [1:0]         req_kind;
   logic [6:0]         req_ready_count;
   logic               req_running_not_idle;
   logic signed [5:0]  req_nice_value;
   logic signed [31:0] req_recent_usage;
   logic               req_thread_is_idle;
   logic               rsp_valid, rsp_stall;
   logic signed [31:0] rsp_value, rsp_load_out;
   logic               csr_write_en;
   logic [0:0]         csr_index;
   logic [7:0]         csr_write_data;
   int                 fail_count, pending_count;
   bit                 long_hold;

   mlfqs_fixed_point_scheduler_math_core u_top (.*);
   mlfqs_math_checker u_checker (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #100ms;
      $display("TB_ERROR");
      $finish;
   end

   // Response side: random stalls, one long hold-off on request
   initial begin
      int wait_cycles;
      rsp_stall = 1;
      @(posedge clock iff !reset);
      forever begin
         if (long_hold) begin
            rsp_stall <= 1;
            repeat (400) @(posedge clock);
            long_hold = 0;
         end
         wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
         if (wait_cycles > 0) begin
            rsp_stall <= 1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 0;
         @(posedge clock iff rsp_valid);
      end
   end

   // One register write, then the write enable is dropped again
   task automatic write_reg(input logic [0:0] idx, input logic [7:0] data);
      csr_write_en <= 1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_en <= 0;
      @(posedge clock);
   endtask

   // Offer one item, with a random gap first
   task automatic send_item(input logic [1:0] k, input logic [6:0] cnt,
         input logic busy, input logic signed [5:0] nice,
         input logic signed [31:0] rec, input logic idle, input bit gaps);
      int gap;
      gap = gaps ? $urandom_range(0, 13) : 0;
      if (gaps && $urandom_range(0, 2) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_kind <= k;
      req_ready_count <= cnt;
      req_running_not_idle <= busy;
      req_nice_value <= nice;
      req_recent_usage <= rec;
      req_thread_is_idle <= idle;
      @(posedge clock iff !req_stall);
   endtask

   task automatic send_random(input bit gaps);
      logic signed [31:0] rec;
      case ($urandom_range(0, 3))
         0: rec = $urandom;
         1: rec = $urandom_range(0, 2000000);
         default: rec = $signed($urandom_range(0, 4000)) - 1000;
      endcase
      send_item(2'($urandom_range(0, 3)),
                7'(($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 64)),
                1'($urandom), 6'($urandom), rec, $urandom_range(0, 4) == 0, gaps);
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      wait (pending_count == 0);
      repeat (80) @(posedge clock);
   endtask

   initial begin
      logic [7:0] hi_set[4];
      logic [7:0] lo_set[4];
      hi_set = '{8'd255, 8'd0, 8'd10, 8'd63};
      lo_set = '{8'd0, 8'd255, 8'd20, 8'd5};
      long_hold = 0;
      reset = 1;
      req_valid = 0;
      req_kind = mlfqs_pkg::KIND_LOAD;
      req_ready_count = 0;
      req_running_not_idle = 0;
      req_nice_value = 0;
      req_recent_usage = 0;
      req_thread_is_idle = 0;
      csr_write_en = 0;
      csr_index = mlfqs_pkg::CSR_MAX_PRIO;
      csr_write_data = 0;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: field extremes, every kind, saturated count, idle thread
      send_item(mlfqs_pkg::KIND_REPORT, 0, 0, 0, 0, 0, 0);
      send_item(mlfqs_pkg::KIND_DECAY, 0, 0, 5, 32'sd1000, 0, 0);
      send_item(mlfqs_pkg::KIND_LOAD, 7'd127, 1, 0, 0, 0, 0);
      send_item(mlfqs_pkg::KIND_LOAD, 7'd64, 0, 0, 0, 0, 0);
      send_item(mlfqs_pkg::KIND_LOAD, 7'd0, 1, 0, 0, 0, 0);
      send_item(mlfqs_pkg::KIND_DECAY, 0, 0, -6'sd32, 32'h7FFFFFFF, 0, 0);
      send_item(mlfqs_pkg::KIND_DECAY, 0, 0, 6'sd31, 32'h80000000, 0, 0);
      send_item(mlfqs_pkg::KIND_DECAY, 0, 0, -6'sd20, 32'hFFFFFFFF, 1, 0);
      send_item(mlfqs_pkg::KIND_PRIO, 0, 0, -6'sd32, 32'h80000000, 0, 0);
      send_item(mlfqs_pkg::KIND_PRIO, 0, 0, 6'sd31, 32'h7FFFFFFF, 0, 0);
      send_item(mlfqs_pkg::KIND_PRIO, 0, 0, 6'sd20, 32'sd0, 0, 0);
      send_item(mlfqs_pkg::KIND_PRIO, 0, 0, -6'sd1, -32'sd7, 0, 0);
      send_item(mlfqs_pkg::KIND_REPORT, 0, 0, 0, 32'h7FFFFFFF, 1, 0);
      send_item(mlfqs_pkg::KIND_REPORT, 7'h7F, 1, 6'h3F, 32'h80000000, 1, 0);
      drain();

      // Random phases under different clamp settings
      for (int ph = 0; ph < 4; ph++) begin
         write_reg(mlfqs_pkg::CSR_MAX_PRIO, hi_set[ph]);
         write_reg(mlfqs_pkg::CSR_MIN_PRIO, lo_set[ph]);
         for (int i = 0; i < 260; i++) begin
            if (ph == 1 && i == 20) long_hold = 1;
            send_random(i % 50 >= 10);
         end
         drain();
      end

      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule
